// ===== rtl/encoder_accel_param_knobs_unit_defines.svh =====
// Assertion macros for the knob block checker.
`ifndef ENCODER_ACCEL_PARAM_KNOBS_UNIT_DEFINES_SVH
`define ENCODER_ACCEL_PARAM_KNOBS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EKN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define EKN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ekn_pkg.sv =====
// Types and constants shared by the knob parameter block.
package ekn_pkg;

	localparam int MAX_TIERS  = 4;
	localparam int TIER_MAX_W = 16;
	localparam int MULT_W     = 4;
	localparam int TIME_W     = 32;
	localparam int LEVEL_W    = 7;
	localparam int BRIGHT_W   = 11;
	localparam int DELTA_W    = 7;
	localparam int STEP_W     = 11;
	localparam int BSTEP_W    = 16;
	localparam int REVERB_W   = 13;
	localparam int REG_IDX_W  = 3;

	typedef enum logic [2:0] {
		CMD_TURN          = 3'd0,
		CMD_TOGGLE_BYPASS = 3'd1,
		CMD_RESET_DRIVE   = 3'd2,
		CMD_BRIGHT_ZERO   = 3'd3,
		CMD_TOGGLE_MUTE   = 3'd4,
		CMD_SCENE         = 3'd5
	} cmd_t;

	localparam logic [1:0] KNOB_DRIVE   = 2'd0;
	localparam logic [1:0] KNOB_BRIGHT  = 2'd1;
	localparam logic [1:0] KNOB_VOLUME  = 2'd2;
	localparam logic [1:0] KNOB_DISPLAY = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_MAX_BASE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MULT_BASE = 3'd4;

	localparam logic [TIER_MAX_W-1:0] TIER_MAX_RST [MAX_TIERS] = '{16'd28, 16'd60, 16'd120, 16'd240};
	localparam logic [MULT_W-1:0]     TIER_MULT_RST[MAX_TIERS] = '{4'd8, 4'd5, 4'd3, 4'd2};
	localparam logic [MULT_W-1:0]     MULT_ONE = 4'd1;

	localparam logic [LEVEL_W-1:0]         DRIVE_RESET  = 7'd15;
	localparam logic [LEVEL_W-1:0]         VOLUME_RESET = 7'd30;
	localparam logic [LEVEL_W-1:0]         LEVEL_MAX    = 7'd100;
	localparam logic signed [BRIGHT_W-1:0] BRIGHT_MIN   = -11'sd600;
	localparam logic signed [BRIGHT_W-1:0] BRIGHT_MAX   = 11'sd800;
	localparam logic signed [BSTEP_W-1:0]  BRIGHT_STEP  = 16'sd20;
	localparam logic [REVERB_W-1:0]        REVERB_BASE  = 13'd1000;
	localparam logic [REVERB_W-1:0]        REVERB_GAIN  = 13'd45;

	typedef struct packed {
		logic [2:0]                 pad;
		logic signed [11:0]         scene_bright_hz;
		logic signed [9:0]          scene_drive_pct;
		logic [TIME_W-1:0]          time_ms;
		logic signed [DELTA_W-1:0]  turn_delta;
	} item_data_t;

	typedef struct packed {
		logic [1:0] knob;
		cmd_t       cmd;
	} item_user_t;

	typedef struct packed {
		logic [1:0]                 pad;
		logic                       mute_flag;
		logic                       bypass_flag;
		logic [LEVEL_W-1:0]         stored_volume_pct;
		logic [LEVEL_W-1:0]         stored_drive_pct;
		logic [LEVEL_W-1:0]         engine_volume_pct;
		logic signed [BRIGHT_W-1:0] brightness_hz;
		logic [REVERB_W-1:0]        reverb_drive_e4;
		logic [LEVEL_W-1:0]         engine_drive_pct;
	} result_t;

endpackage

// ===== rtl/ekn_timing.sv =====
// Per-encoder turn timestamps and speed tier selection.
module ekn_timing
	import ekn_pkg::*;
#(
	parameter int NUM_KNOBS = 3,
	parameter int NUM_TIERS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 turn_en,
	input  logic [1:0]                           knob,
	input  logic [TIME_W-1:0]                    time_ms,
	input  logic [NUM_TIERS-1:0][TIER_MAX_W-1:0] tier_max,
	input  logic [NUM_TIERS-1:0][MULT_W-1:0]     tier_mult,
	output logic [MULT_W-1:0]                    mult
);

	logic [TIME_W-1:0] last_q  [NUM_KNOBS];
	logic              never_q [NUM_KNOBS];
	logic [TIME_W-1:0] sel_last;
	logic              sel_never;
	logic              hit;
	logic              found;
	logic [TIME_W-1:0] interval;

	always_comb begin
		sel_last  = '0;
		sel_never = 1'b1;
		hit       = 1'b0;
		for (int k = 0; k < NUM_KNOBS; k++) begin
			if (32'(knob) == k) begin
				sel_last  = last_q[k];
				sel_never = never_q[k];
				hit       = 1'b1;
			end
		end
	end

	assign interval = time_ms - sel_last;

	always_comb begin
		mult  = MULT_ONE;
		found = 1'b0;
		if (hit && !sel_never) begin
			for (int t = 0; t < NUM_TIERS; t++) begin
				if (!found && interval < TIME_W'(tier_max[t])) begin
					mult  = tier_mult[t];
					found = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KNOBS; k++) begin
				last_q[k]  <= '0;
				never_q[k] <= 1'b1;
			end
		end else if (turn_en) begin
			for (int k = 0; k < NUM_KNOBS; k++) begin
				if (32'(knob) == k) begin
					last_q[k]  <= time_ms;
					never_q[k] <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== rtl/ekn_levels.sv =====
// Parameter levels, bypass and mute flags, and the result they produce.
module ekn_levels
	import ekn_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  cmd_t                       cmd,
	input  logic [1:0]                 knob,
	input  logic signed [DELTA_W-1:0]  turn_delta,
	input  logic [MULT_W-1:0]          mult,
	input  logic signed [9:0]          scene_drive_pct,
	input  logic signed [11:0]         scene_bright_hz,
	output result_t                    res_next
);

	logic [LEVEL_W-1:0]         drive_q;
	logic [LEVEL_W-1:0]         volume_q;
	logic signed [BRIGHT_W-1:0] bright_q;
	logic                       bypass_q;
	logic                       mute_q;

	logic [LEVEL_W-1:0]         drive_d;
	logic [LEVEL_W-1:0]         volume_d;
	logic signed [BRIGHT_W-1:0] bright_d;
	logic                       bypass_d;
	logic                       mute_d;

	logic signed [STEP_W-1:0]   step;
	logic signed [BSTEP_W-1:0]  bstep;
	logic signed [11:0]         drive_sum;
	logic signed [11:0]         volume_sum;
	logic signed [16:0]         bright_sum;
	logic [LEVEL_W-1:0]         drive_turn;
	logic [LEVEL_W-1:0]         volume_turn;
	logic signed [BRIGHT_W-1:0] bright_turn;
	logic [LEVEL_W-1:0]         scene_drive;
	logic signed [BRIGHT_W-1:0] scene_bright;
	logic [LEVEL_W-1:0]         eng_drive;

	assign step  = STEP_W'(turn_delta) * $signed({7'd0, mult});
	assign bstep = BSTEP_W'(step) * BRIGHT_STEP;

	assign drive_sum  = $signed({5'd0, drive_q}) + 12'(step);
	assign volume_sum = $signed({5'd0, volume_q}) + 12'(step);
	assign bright_sum = 17'(bright_q) + 17'(bstep);

	always_comb begin
		if (drive_sum < 0)
			drive_turn = '0;
		else if (drive_sum > $signed({5'd0, LEVEL_MAX}))
			drive_turn = LEVEL_MAX;
		else
			drive_turn = drive_sum[LEVEL_W-1:0];

		if (volume_sum < 0)
			volume_turn = '0;
		else if (volume_sum > $signed({5'd0, LEVEL_MAX}))
			volume_turn = LEVEL_MAX;
		else
			volume_turn = volume_sum[LEVEL_W-1:0];

		if (bright_sum < 17'(BRIGHT_MIN))
			bright_turn = BRIGHT_MIN;
		else if (bright_sum > 17'(BRIGHT_MAX))
			bright_turn = BRIGHT_MAX;
		else
			bright_turn = bright_sum[BRIGHT_W-1:0];

		if (scene_drive_pct < 0)
			scene_drive = '0;
		else if (scene_drive_pct > $signed({3'd0, LEVEL_MAX}))
			scene_drive = LEVEL_MAX;
		else
			scene_drive = scene_drive_pct[LEVEL_W-1:0];

		if (scene_bright_hz < 12'(BRIGHT_MIN))
			scene_bright = BRIGHT_MIN;
		else if (scene_bright_hz > 12'(BRIGHT_MAX))
			scene_bright = BRIGHT_MAX;
		else
			scene_bright = scene_bright_hz[BRIGHT_W-1:0];
	end

	always_comb begin
		drive_d  = drive_q;
		volume_d = volume_q;
		bright_d = bright_q;
		bypass_d = bypass_q;
		mute_d   = mute_q;
		unique case (cmd)
			CMD_TURN: begin
				if (turn_delta != '0) begin
					case (knob)
						KNOB_DRIVE: begin
							bypass_d = 1'b0;
							drive_d  = drive_turn;
						end
						KNOB_BRIGHT: begin
							bright_d = bright_turn;
						end
						KNOB_VOLUME: begin
							mute_d   = 1'b0;
							volume_d = volume_turn;
						end
						default: ;
					endcase
				end
			end
			CMD_TOGGLE_BYPASS: bypass_d = !bypass_q;
			CMD_RESET_DRIVE: begin
				bypass_d = 1'b0;
				drive_d  = DRIVE_RESET;
			end
			CMD_BRIGHT_ZERO: bright_d = '0;
			CMD_TOGGLE_MUTE: mute_d = !mute_q;
			CMD_SCENE: begin
				bypass_d = 1'b0;
				drive_d  = scene_drive;
				bright_d = scene_bright;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q  <= DRIVE_RESET;
			volume_q <= VOLUME_RESET;
			bright_q <= '0;
			bypass_q <= 1'b0;
			mute_q   <= 1'b0;
		end else if (en) begin
			drive_q  <= drive_d;
			volume_q <= volume_d;
			bright_q <= bright_d;
			bypass_q <= bypass_d;
			mute_q   <= mute_d;
		end
	end

	assign eng_drive = bypass_d ? '0 : drive_d;

	always_comb begin
		res_next                   = '0;
		res_next.engine_drive_pct  = eng_drive;
		res_next.reverb_drive_e4   = REVERB_BASE + REVERB_W'(eng_drive) * REVERB_GAIN;
		res_next.brightness_hz     = bright_d;
		res_next.engine_volume_pct = mute_d ? '0 : volume_d;
		res_next.stored_drive_pct  = drive_d;
		res_next.stored_volume_pct = volume_d;
		res_next.bypass_flag       = bypass_d;
		res_next.mute_flag         = mute_d;
	end

endmodule

// ===== rtl/encoder_accel_param_knobs_unit.sv =====
// Top level of the knob parameter block with rotary encoder acceleration.
//
// Knob events arrive on the s_ stream: s_tuser carries the command and the
// encoder index, s_tdata the turn count, the event time and the scene values.
// Each event produces exactly one transfer on the m_ stream with the engine
// drive, reverb drive, brightness, engine volume, stored levels and flags.
// The tier bounds and multipliers are written through the APB port and must
// only change while no event is in flight.
// An event passes an input register and a result register; its result is shown
// once the result register takes it, which waits while a stalled result is
// still held. One event per cycle is taken while the receiver does not stall;
// the rate is set by the single level update stage, since each event sees the
// levels that the previous one left.
// When the receiver stalls, the result register holds and the input register
// keeps one more event; s_tready drops only when both are full.
// Reset restores drive 15, volume 30, brightness 0, clears the flags, marks
// every encoder as not yet turned and loads the default tier table.
module encoder_accel_param_knobs_unit
	import ekn_pkg::*;
#(
	parameter int NUM_KNOBS = 3,
	parameter int NUM_TIERS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// turn_delta, time_ms, scene_drive_pct, scene_bright_hz, zero pad
	input  logic [63:0] s_tdata,
	// cmd, knob
	input  logic [4:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// engine_drive_pct, reverb_drive_e4, brightness_hz, engine_volume_pct,
	// stored_drive_pct, stored_volume_pct, bypass_flag, mute_flag, zero pad
	output logic [55:0] m_tdata
);

	logic [NUM_TIERS-1:0][TIER_MAX_W-1:0] tier_max_q;
	logic [NUM_TIERS-1:0][MULT_W-1:0]     tier_mult_q;
	logic [REG_IDX_W-1:0]                 reg_idx;
	logic                                 cfg_wr;

	logic       s1_valid_q;
	item_data_t data_s1;
	item_user_t user_s1;
	logic       out_valid_q;
	result_t    res_s2;
	result_t    res_next;
	logic       advance;
	logic       fire;
	logic       turn_en;
	logic [MULT_W-1:0] mult;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TIERS; t++) begin
				tier_max_q[t]  <= TIER_MAX_RST[t];
				tier_mult_q[t] <= TIER_MULT_RST[t];
			end
		end else if (cfg_wr) begin
			for (int t = 0; t < NUM_TIERS; t++) begin
				if (reg_idx == REG_MAX_BASE + REG_IDX_W'(t))
					tier_max_q[t] <= pwdata[TIER_MAX_W-1:0];
				if (reg_idx == REG_MULT_BASE + REG_IDX_W'(t))
					tier_mult_q[t] <= pwdata[MULT_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int t = 0; t < NUM_TIERS; t++) begin
			if (reg_idx == REG_MAX_BASE + REG_IDX_W'(t))
				prdata = 32'(tier_max_q[t]);
			if (reg_idx == REG_MULT_BASE + REG_IDX_W'(t))
				prdata = 32'(tier_mult_q[t]);
		end
	end

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !s1_valid_q || advance;
	assign fire     = s1_valid_q && advance;
	assign turn_en  = fire && user_s1.cmd == CMD_TURN && data_s1.turn_delta != '0
		&& user_s1.knob != KNOB_DISPLAY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				s1_valid_q <= s_tvalid;
			if (advance)
				out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= item_data_t'(s_tdata);
			user_s1 <= item_user_t'(s_tuser);
		end
		if (fire)
			res_s2 <= res_next;
	end

	ekn_timing #(
		.NUM_KNOBS(NUM_KNOBS),
		.NUM_TIERS(NUM_TIERS)
	) u_timing (
		.clk       (clk),
		.arst_n    (arst_n),
		.turn_en   (turn_en),
		.knob      (user_s1.knob),
		.time_ms   (data_s1.time_ms),
		.tier_max  (tier_max_q),
		.tier_mult (tier_mult_q),
		.mult      (mult)
	);

	ekn_levels u_levels (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (fire),
		.cmd             (user_s1.cmd),
		.knob            (user_s1.knob),
		.turn_delta      (data_s1.turn_delta),
		.mult            (mult),
		.scene_drive_pct (data_s1.scene_drive_pct),
		.scene_bright_hz (data_s1.scene_bright_hz),
		.res_next        (res_next)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_s2;

endmodule

// ===== rtl/ekn_checker.sv =====
// Port-level checker for the knob parameter block and its bind.
`include "encoder_accel_param_knobs_unit_defines.svh"

module ekn_checker
	import ekn_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	result_t r;

	assign r = result_t'(m_tdata);

	`EKN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Stalled result transfer changed or dropped.")
	`EKN_ASSERT_NOW(a_reverb, m_tvalid, r.reverb_drive_e4 == REVERB_BASE + REVERB_W'(r.engine_drive_pct) * REVERB_GAIN, "Reverb drive does not follow engine drive.")
	`EKN_ASSERT_NOW(a_drive_bypass, m_tvalid, r.engine_drive_pct == (r.bypass_flag ? '0 : r.stored_drive_pct), "Engine drive disagrees with bypass and stored drive.")
	`EKN_ASSERT_NOW(a_volume_mute, m_tvalid, r.engine_volume_pct == (r.mute_flag ? '0 : r.stored_volume_pct), "Engine volume disagrees with mute and stored volume.")
	`EKN_ASSERT_NOW(a_ranges, m_tvalid, r.stored_drive_pct <= LEVEL_MAX && r.stored_volume_pct <= LEVEL_MAX && r.brightness_hz >= BRIGHT_MIN && r.brightness_hz <= BRIGHT_MAX, "Result level out of range.")

endmodule

bind encoder_accel_param_knobs_unit ekn_checker u_ekn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the knob parameter block with encoder acceleration.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ekn_pkg::*;

	localparam int KNOB_COUNT = 3;
	localparam int TIER_COUNT = 4;
	localparam int PHASE_COUNT = 7;
	localparam int EVENTS_PER_PHASE = 250;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_CAP = 100;
	localparam int HOLD_CYCLES = 300;
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	typedef struct {
		logic [2:0]         cmd;
		logic [1:0]         knob;
		logic signed [6:0]  delta;
		logic [31:0]        stamp;
		logic signed [9:0]  scene_drive;
		logic signed [11:0] scene_bright;
	} knob_event_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// turn_delta, time_ms, scene_drive_pct, scene_bright_hz, zero pad
	logic [63:0] s_tdata = '0;
	// cmd, knob
	logic [4:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// engine_drive_pct, reverb_drive_e4, brightness_hz, engine_volume_pct,
	// stored_drive_pct, stored_volume_pct, bypass_flag, mute_flag, zero pad
	logic [55:0] m_tdata;

	// Predicted block state.
	logic [31:0]              turn_stamp[KNOB_COUNT];
	bit                       never_turned[KNOB_COUNT];
	int                       drive_lvl;
	int                       bright_lvl;
	int                       volume_lvl;
	bit                       bypassed;
	bit                       muted;
	logic [TIER_MAX_W-1:0]    tier_bound[MAX_TIERS];
	logic [MULT_W-1:0]        tier_gain[MAX_TIERS];
	logic [TIER_MAX_W-1:0]    next_bound[MAX_TIERS];
	logic [MULT_W-1:0]        next_gain[MAX_TIERS];

	knob_event_t queued_events[$];
	result_t     expected_readouts[$];
	knob_event_t on_wire;
	bit          tx_taken;
	int          tx_gap;
	int          tx_calm;
	int          rx_stall;
	int          rx_calm;
	bit          rx_hold;
	int          accepted_events;
	int          mismatch_count;
	int          cycle_count;
	logic [31:0] clock_ms = 32'd20000;

	encoder_accel_param_knobs_unit #(
		.NUM_KNOBS(KNOB_COUNT),
		.NUM_TIERS(TIER_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int clamp_int(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int speed_factor(input logic [1:0] knob, input logic [31:0] now);
		logic [31:0] dt;
		bit first;
		int i;
		if (knob >= KNOB_COUNT)
			return 1;
		first = never_turned[knob];
		dt = now - turn_stamp[knob];
		turn_stamp[knob] = now;
		never_turned[knob] = 1'b0;
		if (first)
			return 1;
		for (i = 0; i < TIER_COUNT && i < MAX_TIERS; i++)
			if (dt < tier_bound[i])
				return int'(tier_gain[i]);
		return 1;
	endfunction

	function automatic result_t apply_knob_event(input knob_event_t ev);
		result_t r;
		int step;
		int eng;
		case (ev.cmd)
			CMD_TURN: begin
				if (ev.delta != 0 && ev.knob != KNOB_DISPLAY) begin
					step = int'(ev.delta) * speed_factor(ev.knob, ev.stamp);
					if (ev.knob == KNOB_DRIVE) begin
						bypassed = 1'b0;
						drive_lvl = clamp_int(drive_lvl + step, 0, int'(LEVEL_MAX));
					end else if (ev.knob == KNOB_BRIGHT) begin
						bright_lvl = clamp_int(bright_lvl + step * int'(BRIGHT_STEP),
							int'(BRIGHT_MIN), int'(BRIGHT_MAX));
					end else begin
						muted = 1'b0;
						volume_lvl = clamp_int(volume_lvl + step, 0, int'(LEVEL_MAX));
					end
				end
			end
			CMD_TOGGLE_BYPASS: bypassed = !bypassed;
			CMD_RESET_DRIVE: begin
				bypassed = 1'b0;
				drive_lvl = int'(DRIVE_RESET);
			end
			CMD_BRIGHT_ZERO: bright_lvl = 0;
			CMD_TOGGLE_MUTE: muted = !muted;
			CMD_SCENE: begin
				bypassed = 1'b0;
				drive_lvl = clamp_int(int'(ev.scene_drive), 0, int'(LEVEL_MAX));
				bright_lvl = clamp_int(int'(ev.scene_bright), int'(BRIGHT_MIN),
					int'(BRIGHT_MAX));
			end
			default: ;
		endcase
		eng = bypassed ? 0 : drive_lvl;
		r = '0;
		r.engine_drive_pct = LEVEL_W'(eng);
		r.reverb_drive_e4 = REVERB_W'(int'(REVERB_BASE) + int'(REVERB_GAIN) * eng);
		r.brightness_hz = BRIGHT_W'(bright_lvl);
		r.engine_volume_pct = LEVEL_W'(muted ? 0 : volume_lvl);
		r.stored_drive_pct = LEVEL_W'(drive_lvl);
		r.stored_volume_pct = LEVEL_W'(volume_lvl);
		r.bypass_flag = bypassed;
		r.mute_flag = muted;
		return r;
	endfunction

	function automatic knob_event_t make_event(input logic [2:0] cmd, input logic [1:0] knob,
		input int delta, input logic [31:0] stamp, input int sd, input int sb);
		knob_event_t ev;
		ev.cmd = cmd;
		ev.knob = knob;
		ev.delta = 7'(delta);
		ev.stamp = stamp;
		ev.scene_drive = 10'(sd);
		ev.scene_bright = 12'(sb);
		return ev;
	endfunction

	function automatic knob_event_t random_event();
		knob_event_t ev;
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			clock_ms = clock_ms + $urandom_range(0, 40);
		else if (r < 75)
			clock_ms = clock_ms + $urandom_range(0, 300);
		else if (r < 90)
			clock_ms = clock_ms + $urandom_range(0, 70000);
		else if (r < 95)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
		else
			clock_ms = $urandom();
		ev.stamp = clock_ms;
		r = $urandom_range(0, 99);
		if (r < 66)
			ev.cmd = CMD_TURN;
		else if (r < 71)
			ev.cmd = CMD_TOGGLE_BYPASS;
		else if (r < 75)
			ev.cmd = CMD_RESET_DRIVE;
		else if (r < 79)
			ev.cmd = CMD_BRIGHT_ZERO;
		else if (r < 85)
			ev.cmd = CMD_TOGGLE_MUTE;
		else if (r < 97)
			ev.cmd = CMD_SCENE;
		else if (r < 99)
			ev.cmd = CMD_SPARE_A;
		else
			ev.cmd = CMD_SPARE_B;
		r = $urandom_range(0, 9);
		ev.knob = (r < 3) ? KNOB_DRIVE : (r < 6) ? KNOB_BRIGHT :
			(r < 9) ? KNOB_VOLUME : KNOB_DISPLAY;
		if ($urandom_range(0, 4) != 0)
			ev.delta = 7'($urandom_range(0, 10) - 5);
		else
			ev.delta = 7'($urandom());
		if ($urandom_range(0, 1) != 0) begin
			ev.scene_drive = 10'($urandom());
			ev.scene_bright = 12'($urandom());
		end else begin
			ev.scene_drive = 10'($urandom_range(0, 100));
			ev.scene_bright = 12'(int'($urandom_range(0, 1400)) - 600);
		end
		return ev;
	endfunction

	function automatic int pick_idle(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 199);
		if (r == 0) begin
			calm = $urandom_range(40, 120);
			return 0;
		end
		if (r < 140)
			return 0;
		if (r < 184)
			return $urandom_range(1, 3);
		if (r < 198)
			return $urandom_range(4, 12);
		return $urandom_range(30, 60);
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at %0t on result %0d: %s got %0d expected %0d",
				$realtime, accepted_events, what, got, want);
	endtask

	task automatic write_tier_reg(input int idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_tiers();
		int i;
		for (i = 0; i < MAX_TIERS; i++) begin
			write_tier_reg(int'(REG_MAX_BASE) + i, {16'($urandom()), next_bound[i]});
			tier_bound[i] = next_bound[i];
			write_tier_reg(int'(REG_MULT_BASE) + i, {28'($urandom()), next_gain[i]});
			tier_gain[i] = next_gain[i];
		end
	endtask

	task automatic wait_drained();
		while (queued_events.size() != 0 || s_tvalid || expected_readouts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Sender side.
	always @(negedge clk) begin
		if (!s_tvalid || tx_taken) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (queued_events.size() != 0) begin
				item_data_t d;
				item_user_t u;
				on_wire = queued_events.pop_front();
				d = '0;
				d.turn_delta = on_wire.delta;
				d.time_ms = on_wire.stamp;
				d.scene_drive_pct = on_wire.scene_drive;
				d.scene_bright_hz = on_wire.scene_bright;
				u.knob = on_wire.knob;
				u.cmd = cmd_t'(on_wire.cmd);
				s_tdata <= d;
				s_tuser <= u;
				s_tvalid <= 1'b1;
				tx_gap = pick_idle(tx_calm);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver side.
	always @(negedge clk) begin
		if (rx_hold) begin
			m_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
			rx_stall = pick_idle(rx_calm);
		end
	end

	// Result checking and prediction of each accepted transfer.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		tx_taken = (s_tvalid === 1'b1) && (s_tready === 1'b1);
		if (m_tvalid === 1'b1 && m_tready) begin
			got = result_t'(m_tdata);
			if (expected_readouts.size() == 0) begin
				flag_mismatch("result with nothing expected", m_tdata, 0);
			end else begin
				want = expected_readouts.pop_front();
				if (got.engine_drive_pct !== want.engine_drive_pct)
					flag_mismatch("engine_drive_pct", got.engine_drive_pct,
						want.engine_drive_pct);
				if (got.reverb_drive_e4 !== want.reverb_drive_e4)
					flag_mismatch("reverb_drive_e4", got.reverb_drive_e4,
						want.reverb_drive_e4);
				if (got.brightness_hz !== want.brightness_hz)
					flag_mismatch("brightness_hz", got.brightness_hz, want.brightness_hz);
				if (got.engine_volume_pct !== want.engine_volume_pct)
					flag_mismatch("engine_volume_pct", got.engine_volume_pct,
						want.engine_volume_pct);
				if (got.stored_drive_pct !== want.stored_drive_pct)
					flag_mismatch("stored_drive_pct", got.stored_drive_pct,
						want.stored_drive_pct);
				if (got.stored_volume_pct !== want.stored_volume_pct)
					flag_mismatch("stored_volume_pct", got.stored_volume_pct,
						want.stored_volume_pct);
				if (got.bypass_flag !== want.bypass_flag)
					flag_mismatch("bypass_flag", got.bypass_flag, want.bypass_flag);
				if (got.mute_flag !== want.mute_flag)
					flag_mismatch("mute_flag", got.mute_flag, want.mute_flag);
			end
		end
		if (tx_taken) begin
			expected_readouts.push_back(apply_knob_event(on_wire));
			accepted_events++;
		end
	end

	// Long receiver hold-offs while the sender keeps offering transfers.
	initial begin
		wait (accepted_events >= 400);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
		wait (accepted_events >= 1100);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int i;
		int phase;
		for (i = 0; i < KNOB_COUNT; i++) begin
			turn_stamp[i] = '0;
			never_turned[i] = 1'b1;
		end
		drive_lvl = int'(DRIVE_RESET);
		bright_lvl = 0;
		volume_lvl = int'(VOLUME_RESET);
		bypassed = 1'b0;
		muted = 1'b0;
		tier_bound = TIER_MAX_RST;
		tier_gain = TIER_MULT_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Acceleration tiers, saturation, flags and scene clamping at the reset table.
		queued_events.push_back(make_event(CMD_TURN, KNOB_DRIVE, 1, 32'd0, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_DRIVE, 1, 32'd10, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_DRIVE, -1, 32'd50, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_DRIVE, 2, 32'd150, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_DRIVE, 1, 32'd350, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_DRIVE, 1, 32'd1000, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_DRIVE, 0, 32'd1005, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_DRIVE, 63, 32'd1010, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_DRIVE, -64, 32'd1020, 0, 0));
		queued_events.push_back(make_event(CMD_TOGGLE_BYPASS, KNOB_DRIVE, 0, 32'd0, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_DRIVE, 5, 32'd5000, 0, 0));
		queued_events.push_back(make_event(CMD_TOGGLE_BYPASS, KNOB_DRIVE, 0, 32'd0, 0, 0));
		queued_events.push_back(make_event(CMD_RESET_DRIVE, KNOB_DRIVE, 0, 32'd0, 0, 0));
		queued_events.push_back(make_event(CMD_TOGGLE_BYPASS, KNOB_DRIVE, 0, 32'd0, 0, 0));
		queued_events.push_back(make_event(CMD_SCENE, KNOB_DRIVE, 0, 32'd0, -512, -2048));
		queued_events.push_back(make_event(CMD_SCENE, KNOB_DRIVE, 0, 32'd0, 511, 2047));
		queued_events.push_back(make_event(CMD_SCENE, KNOB_DRIVE, 0, 32'd0, 42, -300));
		queued_events.push_back(make_event(CMD_TURN, KNOB_BRIGHT, 63, 32'hFFFF_FFFF, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_BRIGHT, -64, 32'd9, 0, 0));
		queued_events.push_back(make_event(CMD_BRIGHT_ZERO, KNOB_BRIGHT, 0, 32'd0, 0, 0));
		queued_events.push_back(make_event(CMD_TOGGLE_MUTE, KNOB_VOLUME, 0, 32'd0, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_VOLUME, -64, 32'd77, 0, 0));
		queued_events.push_back(make_event(CMD_TOGGLE_MUTE, KNOB_VOLUME, 0, 32'd0, 0, 0));
		queued_events.push_back(make_event(CMD_TURN, KNOB_DISPLAY, 63, 32'd7, 0, 0));
		queued_events.push_back(make_event(CMD_SPARE_A, KNOB_DRIVE, 9, 32'd0, 77, 99));
		queued_events.push_back(make_event(CMD_SPARE_B, KNOB_VOLUME, -9, 32'd0, 77, 99));
		wait_drained();

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				1, 5: begin
					for (i = 0; i < MAX_TIERS; i++) begin
						next_bound[i] = TIER_MAX_W'($urandom_range(0, 65535));
						next_gain[i] = MULT_W'($urandom_range(0, 15));
					end
				end
				2: begin
					next_bound = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
					next_gain = '{4'hF, 4'hF, 4'hF, 4'hF};
				end
				3: begin
					next_bound = '{16'd0, 16'd0, 16'd0, 16'd0};
					next_gain = '{4'hF, 4'hF, 4'hF, 4'hF};
				end
				4: begin
					next_bound = '{16'd16, 16'd64, 16'd300, 16'hFFFF};
					next_gain = '{4'd0, 4'hF, 4'd1, 4'd0};
				end
				6: begin
					next_bound = TIER_MAX_RST;
					next_gain = TIER_MULT_RST;
				end
				default: ;
			endcase
			if (phase != 0)
				program_tiers();
			@(posedge clk);
			repeat (EVENTS_PER_PHASE) queued_events.push_back(random_event());
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ekn_pkg.sv
rtl/ekn_timing.sv
rtl/ekn_levels.sv
rtl/encoder_accel_param_knobs_unit.sv
rtl/ekn_checker.sv
verif/tb_top.sv
